@@ src/pqbp_pkg.sv @@
// Shared types, constants and helper functions for the pixel quantizer and bit packer.
package pqbp_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int CODE_W_BITS = 4;
  localparam int ACC_BITS    = 15;
  localparam int PEND_BITS   = 4;
  localparam int CNT_BITS    = 3;

  localparam logic [PIXEL_BITS-1:0] RESET_STEP = 8'd2;
  // last iteration of the bit-serial divider
  localparam logic [CNT_BITS-1:0]   DIV_LAST   = 3'd7;
  localparam logic [PEND_BITS-1:0]  BYTE_BITS  = 4'd8;

  // commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic div_step;
    logic pack;
    logic emit_full;
    logic emit_flush;
  } pqbp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pend_ge8;
    logic pend_nz;
    logic last;
    logic out_free;
  } pqbp_stat_t;

  // a step of zero behaves as a step of one
  function automatic logic [PIXEL_BITS-1:0] eff_step(logic [PIXEL_BITS-1:0] s);
    return (s == '0) ? 8'd1 : s;
  endfunction

  // smallest w with 2^w >= floor(256/step), i.e. 256 < step * (2^w + 1); capped at 8
  function automatic logic [CODE_W_BITS-1:0] code_width(logic [PIXEL_BITS-1:0] step);
    logic [16:0]            prod;
    logic [CODE_W_BITS-1:0] w;
    logic                   found;
    w     = 4'd8;
    found = 1'b0;
    for (int i = 0; i < PIXEL_BITS; i++) begin
      prod = (17'(step) << i) + 17'(step);
      if (!found && (prod > 17'd256)) begin
        w     = CODE_W_BITS'(i);
        found = 1'b1;
      end
    end
    return w;
  endfunction

endpackage

@@ src/pqbp_datapath.sv @@
// Datapath: step register, bit-serial divider, bit accumulator and output word register.
module pqbp_datapath
  import pqbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [PIXEL_BITS-1:0] cfg_data,
  input  logic [PIXEL_BITS-1:0] s_tdata,
  input  logic                  s_tlast,
  input  pqbp_cmd_t             cmd,
  output pqbp_stat_t            stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,
  output logic                  m_tlast
);

  logic [PIXEL_BITS-1:0]  step_div;
  logic [CODE_W_BITS-1:0] width;
  logic [PIXEL_BITS-1:0]  dvd;       // dividend in, quotient out
  logic [PIXEL_BITS-1:0]  rem;
  logic                   last_flag;
  logic [ACC_BITS-1:0]    acc;
  logic [PEND_BITS-1:0]   pend;

  logic [PIXEL_BITS:0]    rem_sh;
  logic                   fits;
  logic [PIXEL_BITS-1:0]  rem_next;
  logic [PIXEL_BITS-1:0]  max_code;
  logic [PIXEL_BITS-1:0]  level;
  logic                   out_free;

  // one restoring division step per cycle
  always_comb begin
    rem_sh   = {rem, dvd[PIXEL_BITS-1]};
    fits     = (rem_sh >= {1'b0, step_div});
    rem_next = fits ? PIXEL_BITS'(rem_sh - {1'b0, step_div}) : rem_sh[PIXEL_BITS-1:0];
  end

  // saturate the level to the code width
  always_comb begin
    max_code = PIXEL_BITS'((9'd1 << width) - 9'd1);
    level    = (dvd > max_code) ? max_code : dvd;
  end

  assign out_free = !m_tvalid || m_tready;

  assign stat.pend_ge8 = (pend >= BYTE_BITS);
  assign stat.pend_nz  = (pend != '0);
  assign stat.last     = last_flag;
  assign stat.out_free = out_free;

  // configuration: step and derived code width
  always_ff @(posedge clk) begin
    if (rst) begin
      step_div <= RESET_STEP;
      width    <= code_width(RESET_STEP);
    end else if (cfg_valid) begin
      step_div <= eff_step(cfg_data);
      width    <= code_width(eff_step(cfg_data));
    end
  end

  // divider registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      dvd       <= s_tdata;
      rem       <= '0;
      last_flag <= s_tlast;
    end else if (cmd.div_step) begin
      dvd <= {dvd[PIXEL_BITS-2:0], fits};
      rem <= rem_next;
    end
  end

  // bit accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      pend <= '0;
    end else if (cmd.pack) begin
      acc  <= acc | (ACC_BITS'(level) << pend[2:0]);
      pend <= pend + PEND_BITS'(width);
    end else if (cmd.emit_full) begin
      acc  <= acc >> 8;
      pend <= pend - BYTE_BITS;
    end else if (cmd.emit_flush) begin
      acc  <= '0;
      pend <= '0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_full || (cmd.emit_flush && stat.pend_nz)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_full) begin
      m_tdata <= acc[7:0];
      m_tlast <= last_flag && (pend == BYTE_BITS);
    end else if (cmd.emit_flush && stat.pend_nz) begin
      m_tdata <= acc[7:0];
      m_tlast <= 1'b1;
    end
  end

  // no code bits above the pending count
  a_acc_clean: assert property (@(posedge clk) disable iff (rst)
    (acc >> pend) == '0)
    else $error("accumulator holds bits above pending count");

  // a full byte is only taken when eight bits are there and the output is free
  a_full_ok: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_full |-> (stat.pend_ge8 && out_free))
    else $error("full byte emitted without eight bits or free output");

  // a flush leaves the packer empty
  a_flush_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_flush |=> (pend == '0 && acc == '0))
    else $error("packer not cleared after flush");

endmodule

@@ src/pqbp_ctrl.sv @@
// Controller: sequences input accept, divide, pack and byte emission for one pixel.
module pqbp_ctrl
  import pqbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  pqbp_stat_t stat,
  output pqbp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PACK,
    ST_FULL,
    ST_FLUSH
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CNT_BITS-1:0] cnt;

  assign s_tready = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_LAST) state_next = ST_PACK;
      end
      ST_PACK: begin
        cmd.pack   = 1'b1;
        state_next = ST_FULL;
      end
      ST_FULL: begin
        if (!stat.pend_ge8) begin
          state_next = stat.last ? ST_FLUSH : ST_IDLE;
        end else if (stat.out_free) begin
          cmd.emit_full = 1'b1;
          state_next    = stat.last ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!stat.pend_nz || stat.out_free) begin
          cmd.emit_flush = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state and iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (cmd.load_in) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + CNT_BITS'(1);
      end
    end
  end

endmodule

@@ src/pixel_quantize_bit_packer.sv @@
// Top level of the pixel quantizer and bit packer.
//
// Pixels arrive on the s_ stream one word at a time: s_tdata is the 8-bit grey
// value, s_tlast marks the last pixel of an image. Each pixel is divided by the
// quant_step register, saturated to a code of W bits (W follows from the step)
// and appended LSB first to a bit accumulator. Each full byte leaves on the m_
// stream, earliest bit in bit 0; the last pixel flushes a zero-filled partial
// byte, and the final byte of an image carries m_tlast.
// The step is written over the cfg_ channel (always ready); the user must do this
// only while the block is idle, and the block itself does not enforce it. Each
// pixel passes through accept, 8 divide iterations, pack and byte emit, and a last
// pixel also through the flush. A new pixel is accepted only from idle.
// The output register holds a byte while m_tready is low; the block keeps
// working on the next pixel and only waits once it has another byte to send.
// Reset clears the accumulator, empties the output register and sets the step to 2.
module pixel_quantize_bit_packer
  import pqbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,   // [7:0] quant_step
  // pixel stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] pixel
  input  logic       s_tlast,    // last_pixel
  // packed byte stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] packed_byte
  output logic       m_tlast     // last_byte
);

  pqbp_cmd_t  cmd;
  pqbp_stat_t stat;

  assign cfg_ready = 1'b1;

  pqbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pqbp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
